// ===== design/vpwp_pkg.sv =====
// shared types, constants and packing functions for the pixel word packer
package vpwp_pkg;

  localparam int COMP_W       = 12;
  localparam int WORD_W       = 32;
  localparam int GROUP_PIXELS = 8;
  localparam int GROUP_WORDS  = (GROUP_PIXELS * 3 * COMP_W) / WORD_W;
  localparam int WORD_IDX_W   = $clog2(GROUP_WORDS);
  localparam int GROUP_CNT_W  = $clog2(GROUP_PIXELS);
  localparam int FMT_W        = 3;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [FMT_W-1:0] FMT_ARGB = 3'd0;
  localparam logic [FMT_W-1:0] FMT_BGRA = 3'd1;
  localparam logic [FMT_W-1:0] FMT_R210 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_R12L = 3'd3;
  localparam logic [FMT_W-1:0] FMT_R12B = 3'd4;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              frame_end;
  } pixel_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic              group_last;
  } word_t;

  // one stored pixel of an r12 group, blue in the top bits
  typedef logic [3*COMP_W-1:0] group_pixel_t;

  // queue entry: either one finished word (in words[0]) or a whole r12 group
  typedef struct packed {
    logic                                is_group;
    logic                                swap;
    logic [GROUP_WORDS-1:0][WORD_W-1:0]  words;
  } cmd_t;

  function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
    swap_bytes = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [WORD_W-1:0] make_argb(input logic [COMP_W-1:0] r,
                                                  input logic [COMP_W-1:0] g,
                                                  input logic [COMP_W-1:0] b);
    make_argb = {b[7:0], g[7:0], r[7:0], 8'h00};
  endfunction

  function automatic logic [WORD_W-1:0] make_r210(input logic [COMP_W-1:0] r,
                                                  input logic [COMP_W-1:0] g,
                                                  input logic [COMP_W-1:0] b);
    make_r210 = {b[7:0], g[5:0], b[9:8], r[3:0], g[9:6], 2'b00, r[9:4]};
  endfunction

endpackage

// ===== design/vpwp_front.sv =====
// front end: accepts pixels, keeps the r12 group and issues queue entries
module vpwp_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           format_write,
  input  logic [vpwp_pkg::FMT_W-1:0]     format_data,
  input  logic                           pixel_valid,
  output logic                           pixel_ready,
  input  vpwp_pkg::pixel_t               pixel,
  input  logic                           queue_full,
  output logic                           push,
  output vpwp_pkg::cmd_t                 cmd
);

  logic [vpwp_pkg::FMT_W-1:0]          pixel_format;
  logic [vpwp_pkg::GROUP_CNT_W-1:0]    group_count;
  logic [vpwp_pkg::GROUP_CNT_W-1:0]    group_count_next;
  vpwp_pkg::group_pixel_t              group_pixels [vpwp_pkg::GROUP_PIXELS];
  vpwp_pkg::group_pixel_t              cur_pixel;
  logic [vpwp_pkg::GROUP_PIXELS*3*vpwp_pkg::COMP_W-1:0] group_bits;
  logic                                accept;
  logic                                is_r12;
  logic                                group_done;

  assign pixel_ready = !queue_full;
  assign accept      = pixel_valid && pixel_ready;
  assign cur_pixel   = {pixel.blue, pixel.green, pixel.red};
  assign is_r12      = (pixel_format == vpwp_pkg::FMT_R12L) ||
                       (pixel_format == vpwp_pkg::FMT_R12B);
  assign group_done  = group_count == vpwp_pkg::GROUP_CNT_W'(vpwp_pkg::GROUP_PIXELS - 1);

  // stored pixels plus the one arriving now form the whole group
  always_comb begin
    for (int p = 0; p < vpwp_pkg::GROUP_PIXELS - 1; p++) begin
      group_bits[p*3*vpwp_pkg::COMP_W +: 3*vpwp_pkg::COMP_W] = group_pixels[p];
    end
    group_bits[(vpwp_pkg::GROUP_PIXELS-1)*3*vpwp_pkg::COMP_W +: 3*vpwp_pkg::COMP_W] =
      cur_pixel;
  end

  always_comb begin
    cmd              = '0;
    push             = 1'b0;
    group_count_next = '0;
    case (pixel_format)
      vpwp_pkg::FMT_ARGB: begin
        push          = accept;
        cmd.words[0]  = vpwp_pkg::make_argb(pixel.red, pixel.green, pixel.blue);
      end
      vpwp_pkg::FMT_BGRA: begin
        push          = accept;
        cmd.words[0]  = vpwp_pkg::swap_bytes(
                          vpwp_pkg::make_argb(pixel.red, pixel.green, pixel.blue));
      end
      vpwp_pkg::FMT_R210: begin
        push          = accept;
        cmd.words[0]  = vpwp_pkg::make_r210(pixel.red, pixel.green, pixel.blue);
      end
      vpwp_pkg::FMT_R12L, vpwp_pkg::FMT_R12B: begin
        push          = accept && group_done;
        cmd.is_group  = 1'b1;
        cmd.swap      = pixel_format == vpwp_pkg::FMT_R12B;
        cmd.words     = group_bits;
        if (!group_done && !pixel.frame_end) begin
          group_count_next = group_count + 1'b1;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= vpwp_pkg::FMT_ARGB;
      group_count  <= '0;
    end else if (format_write) begin
      pixel_format <= format_data;
      group_count  <= '0;
    end else if (accept) begin
      group_count  <= group_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_r12) begin
      group_pixels[group_count] <= cur_pixel;
    end
  end

endmodule

// ===== design/vpwp_queue.sv =====
// short queue between the front and back ends
module vpwp_queue #(
  parameter int DEPTH = vpwp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vpwp_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output vpwp_pkg::cmd_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vpwp_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== design/vpwp_back.sv =====
// back end: walks the queue head word by word into the output register
module vpwp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  vpwp_pkg::cmd_t  head,
  output logic            pop,
  output logic            word_valid,
  input  logic            word_ready,
  output vpwp_pkg::word_t word
);

  logic [vpwp_pkg::WORD_IDX_W-1:0] word_idx;
  logic [vpwp_pkg::WORD_W-1:0]     sel_word;
  logic                            sel_last;
  logic                            load;

  assign load     = head_valid && (!word_valid || word_ready);
  assign sel_last = !head.is_group ||
                    (word_idx == vpwp_pkg::WORD_IDX_W'(vpwp_pkg::GROUP_WORDS - 1));
  assign pop      = load && sel_last;

  always_comb begin
    sel_word = head.words[word_idx];
    if (head.swap) begin
      sel_word = vpwp_pkg::swap_bytes(sel_word);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      word_idx   <= '0;
    end else begin
      if (load) begin
        word_valid <= 1'b1;
        word_idx   <= sel_last ? '0 : word_idx + 1'b1;
      end else if (word_ready) begin
        word_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word.packed_word <= sel_word;
      word.group_last  <= sel_last;
    end
  end

endmodule

// ===== design/video_pixel_word_packer_core.sv =====
// top level of the pixel word packer
//
// pixel channel (pixel_valid/pixel_ready/pixel) takes one rgb pixel per
// transaction; word channel (word_valid/word_ready/word) gives packed 32-bit
// words. format_write/format_data load the pixel format (argb, bgra, r210,
// r12l, r12b) and drop any partial r12 group; write it only while idle.
// argb, bgra and r210 give one word per pixel with group_last set.
// r12 formats gather eight pixels; the eighth gives nine words, the ninth
// with group_last set. frame_end on an earlier pixel drops the group.
// the first word passes through the queue and then the output register.
// throughput: one pixel per cycle for single-word formats while the queue has
// room; r12 formats are bound by the output register at one word per cycle.
// a queue of QUEUE_DEPTH entries sits between the pixel side and the word
// side, so pixels keep flowing while the receiver stalls until it fills.
// reset selects argb and empties the group and the queue.
module video_pixel_word_packer_core #(
  parameter int QUEUE_DEPTH = vpwp_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        format_write,
  input  logic [vpwp_pkg::FMT_W-1:0]  format_data,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  vpwp_pkg::pixel_t            pixel,
  output logic                        word_valid,
  input  logic                        word_ready,
  output vpwp_pkg::word_t             word
);

  logic            push;
  logic            pop;
  logic            queue_full;
  logic            head_valid;
  vpwp_pkg::cmd_t  push_cmd;
  vpwp_pkg::cmd_t  head;

  vpwp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .format_write (format_write),
    .format_data  (format_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .queue_full   (queue_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  vpwp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  vpwp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word)
  );

endmodule
